FILE: rtl/core/rate_monotonic_tick_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler: assertion macros
// Shared property shorthands for the checker, clocked on aclk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef RATE_MONOTONIC_TICK_SCHEDULER_TOP_DEFINES_SVH
`define RATE_MONOTONIC_TICK_SCHEDULER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define RMTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rmts_pkg.sv
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler: shared package
// Sizes, stream field layout and the structs passed between top and cells.
// ----------------------------------------------------------------------------
package rmts_pkg;

    // Table size and time width
    localparam int MAX_TASKS = 8;
    localparam int TIME_BITS = 16;
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    // Fixed field widths on the ports
    localparam int SLOT_FW   = 3;
    localparam int IDENT_W   = 8;
    localparam int TIME_FW   = 16;
    localparam int COUNT_W   = 4;
    localparam int MASK_W    = 8;

    // Input tdata layout: slot, task_ident, compute_units, period_units
    localparam int IN_SLOT_LO    = 0;
    localparam int IN_IDENT_LO   = IN_SLOT_LO + SLOT_FW;
    localparam int IN_COMP_LO    = IN_IDENT_LO + IDENT_W;
    localparam int IN_PER_LO     = IN_COMP_LO + TIME_FW;
    localparam int IN_USED_W     = IN_PER_LO + TIME_FW;
    localparam int S_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout: running_slot, running_ident, job_started, miss_mask
    localparam int OUT_SLOT_LO   = 0;
    localparam int OUT_IDENT_LO  = OUT_SLOT_LO + SLOT_FW;
    localparam int OUT_START_BIT = OUT_IDENT_LO + IDENT_W;
    localparam int OUT_MASK_LO   = OUT_START_BIT + 1;
    localparam int OUT_USED_W    = OUT_MASK_LO + MASK_W;
    localparam int M_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

    // tuser codes on the input side
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef logic [SLOT_W-1:0]    slot_idx_t;
    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [IDENT_W-1:0]   ident_t;

    // Best candidate so far, handed from cell to cell
    typedef struct packed {
        logic      found;
        time_t     period;
        slot_idx_t slot;
        ident_t    ident;
        logic      started;
    } cand_t;

    localparam cand_t CAND_NONE = '{found: 1'b0, period: '0, slot: '0,
                                    ident: '0, started: 1'b0};

    // Slot load broadcast
    typedef struct packed {
        ident_t ident;
        time_t  compute;
        time_t  period;
    } load_t;

    // Tick update broadcast
    typedef struct packed {
        logic      en;
        logic      found;
        slot_idx_t pick;
    } apply_t;

endpackage

FILE: rtl/core/rate_monotonic_tick_scheduler_top.sv
// Order: a tick's candidate ripples through the cell registers in ST_SELECT,
//   then enters the result register once the output is free; a load takes
//   effect in the next cycle. Throughput: no input while a tick is in progress,
//   else one load per cycle; the best candidate ripples one cell per cycle.
// Reset: synchronous, active low; task_count returns to 1 and every slot to
//   an empty task of period one, with no result pending.
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler: top level
// Stream front end, tick sequencer, slot cell chain and result register.
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler_top import rmts_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // slot, task_ident, compute_units, period_units
    input  logic                 s_tuser,  // req_type
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // running_slot, running_ident, job_started, miss_mask
    output logic                 m_tuser,  // cpu_idle
    // Configuration
    input  logic                 cfg_we,
    input  logic [COUNT_W-1:0]   cfg_wdata  // task_count
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SELECT = 3'b010,
        ST_APPLY  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    slot_idx_t              step_reg, step_next;
    logic [COUNT_W-1:0]     task_count_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg;

    logic                   in_fire;
    logic                   out_free;
    logic                   load_ok;
    logic [SLOT_FW-1:0]     f_slot;
    load_t                  load;
    apply_t                 apply;
    cand_t                  chain [MAX_TASKS];
    cand_t                  best;
    logic [MAX_TASKS-1:0]   miss;
    logic [MASK_W-1:0]      miss_vec;
    logic [SLOT_FW-1:0]     out_slot;
    logic [31:0]            slot_wide;

    // Input fields
    assign f_slot       = s_tdata[IN_SLOT_LO +: SLOT_FW];
    assign load.ident   = s_tdata[IN_IDENT_LO +: IDENT_W];
    assign load.compute = time_t'(s_tdata[IN_COMP_LO +: TIME_FW]);
    assign load.period  = time_t'(s_tdata[IN_PER_LO +: TIME_FW]);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign load_ok  = in_fire && (s_tuser == REQ_LOAD) && (32'(f_slot) < MAX_TASKS);
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer: wait for the candidate to leave the last cell, then update
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (in_fire && (s_tuser == REQ_TICK)) begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT: begin
                step_next = step_reg + slot_idx_t'(1);
                if (step_reg == slot_idx_t'(MAX_TASKS - 1)) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Task count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= COUNT_W'(1);
        end else if (cfg_we) begin
            task_count_reg <= cfg_wdata;
        end
    end

    // Slot cell chain
    assign best        = chain[MAX_TASKS-1];
    assign apply.en    = (state_reg == ST_APPLY) && out_free;
    assign apply.found = best.found;
    assign apply.pick  = best.slot;

    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        cand_t cin;
        if (k == 0) begin : g_head
            assign cin = CAND_NONE;
        end else begin : g_link
            assign cin = chain[k-1];
        end
        rmts_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (slot_idx_t'(k)),
            .active   (32'(task_count_reg) > k),
            .load_hit (load_ok && (32'(f_slot) == k)),
            .load     (load),
            .apply    (apply),
            .cand_in  (cin),
            .cand_reg (chain[k]),
            .miss     (miss[k])
        );
    end

    // Miss bits exist for the first eight slots only
    for (genvar b = 0; b < MASK_W; b++) begin : g_mask
        if (b < MAX_TASKS) begin : g_bit
            assign miss_vec[b] = miss[b];
        end else begin : g_zero
            assign miss_vec[b] = 1'b0;
        end
    end

    assign slot_wide = 32'(best.slot);
    assign out_slot  = slot_wide[SLOT_FW-1:0];

    // Result word packing
    always_comb begin
        m_tdata_next                                = '0;
        m_tdata_next[OUT_SLOT_LO +: SLOT_FW]        = out_slot;
        m_tdata_next[OUT_IDENT_LO +: IDENT_W]       = best.ident;
        m_tdata_next[OUT_START_BIT]                 = best.found && best.started;
        m_tdata_next[OUT_MASK_LO +: MASK_W]         = miss_vec;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (apply.en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply.en) begin
            m_tuser_reg <= !best.found;
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/core/rmts_cell.sv
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler: task slot cell
// Holds one slot's task state, merges itself into the passing candidate and
// applies the per-tick work and release countdown update.
// ----------------------------------------------------------------------------
module rmts_cell import rmts_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  slot_idx_t cell_idx,
    input  logic      active,
    input  logic      load_hit,
    input  load_t     load,
    input  apply_t    apply,
    input  cand_t     cand_in,
    output cand_t     cand_reg,
    output logic      miss
);

    ident_t ident_reg,   ident_next;
    time_t  compute_reg, compute_next;
    time_t  period_reg,  period_next;
    time_t  rem_reg,     rem_next;
    time_t  cd_reg,      cd_next;
    cand_t  cand_next;

    logic   take_own;
    logic   sel;
    time_t  rem_run;
    time_t  cd_dec;
    logic   wrap;

    // Candidate merge: later slot wins on equal period
    assign take_own = active && (rem_reg != '0) &&
                      (!cand_in.found || (period_reg <= cand_in.period));

    always_comb begin
        cand_next = cand_in;
        if (take_own) begin
            cand_next.found   = 1'b1;
            cand_next.period  = period_reg;
            cand_next.slot    = cell_idx;
            cand_next.ident   = ident_reg;
            cand_next.started = (rem_reg == compute_reg);
        end
    end

    // Tick update: run one unit if picked, then count down the release
    assign sel     = apply.found && (apply.pick == cell_idx);
    assign rem_run = sel ? rem_reg - time_t'(1) : rem_reg;
    assign cd_dec  = cd_reg - time_t'(1);
    assign wrap    = active && (cd_dec == '0);
    assign miss    = wrap && (rem_run != '0);

    always_comb begin
        ident_next   = ident_reg;
        compute_next = compute_reg;
        period_next  = period_reg;
        rem_next     = rem_reg;
        cd_next      = cd_reg;
        priority if (load_hit) begin
            ident_next   = load.ident;
            compute_next = load.compute;
            period_next  = load.period;
            rem_next     = load.compute;
            cd_next      = load.period;
        end else if (apply.en) begin
            if (!active) begin
                rem_next = rem_run;
            end else if (wrap) begin
                rem_next = compute_reg;
                cd_next  = period_reg;
            end else begin
                rem_next = rem_run;
                cd_next  = cd_dec;
            end
        end
    end

    // Slot state, reset to an empty task of period one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ident_reg   <= '0;
            compute_reg <= '0;
            period_reg  <= time_t'(1);
            rem_reg     <= '0;
            cd_reg      <= time_t'(1);
        end else begin
            ident_reg   <= ident_next;
            compute_reg <= compute_next;
            period_reg  <= period_next;
            rem_reg     <= rem_next;
            cd_reg      <= cd_next;
        end
    end

    // Candidate stage towards the next cell
    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
    end

endmodule

FILE: rtl/core/rmts_checker.sv
// ----------------------------------------------------------------------------
// Rate-monotonic tick scheduler: port checker
// Watches the stream ports of the top level; bound in below.
// ----------------------------------------------------------------------------
`include "rate_monotonic_tick_scheduler_top_defines.svh"

module rmts_checker import rmts_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // A stalled result transaction holds
    `RMTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result transaction changed or dropped")

    // An idle tick reports slot, identifier and job start as zero
    `RMTS_ASSERT_SAME(a_idle_zero, m_tvalid && m_tuser, m_tdata[OUT_START_BIT:0] == '0, "idle tick with non-zero slot fields")

    // A load transaction never creates a result
    `RMTS_ASSERT_NEXT(a_load_silent, s_tvalid && s_tready && s_tuser && !m_tvalid, !m_tvalid, "load transaction produced a result")

    // A tick transaction blocks the input while it is scheduled
    `RMTS_ASSERT_NEXT(a_tick_busy, s_tvalid && s_tready && !s_tuser, !s_tready, "input ready while a tick is scheduled")

endmodule

bind rate_monotonic_tick_scheduler_top rmts_checker u_rmts_checker (.*);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the rate-monotonic tick scheduler
// Streams task loads and ticks into the block while both sides stall at
// random. A model of the task table predicts each tick's outcome,
// and the model's outcomes are compared field by field with the result stream.
// ----------------------------------------------------------------------------
module tb_top;
    import rmts_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE       = MAX_TASKS + 4;  // result latency plus margin
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 1100;
    localparam int CYCLE_LIMIT  = 400000;

    // One input transaction, split into its fields
    typedef struct {
        logic                 req;
        logic [SLOT_FW-1:0]   slot;
        logic [IDENT_W-1:0]   ident;
        logic [TIME_FW-1:0]   compute;
        logic [TIME_FW-1:0]   period;
    } sched_req_t;

    // One tick outcome, as the result stream carries it
    typedef struct {
        logic                 idle;
        logic [SLOT_FW-1:0]   slot;
        logic [IDENT_W-1:0]   ident;
        logic                 started;
        logic [MASK_W-1:0]    misses;
    } tick_outcome_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = REQ_TICK;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [COUNT_W-1:0]   cfg_wdata = '0;

    // Scheduler model state
    logic [COUNT_W-1:0]   task_count_mirror;
    logic [IDENT_W-1:0]   ident_of   [MAX_TASKS];
    logic [TIME_BITS-1:0] compute_of [MAX_TASKS];
    logic [TIME_BITS-1:0] period_of  [MAX_TASKS];
    logic [TIME_BITS-1:0] work_left  [MAX_TASKS];
    logic [TIME_BITS-1:0] countdown  [MAX_TASKS];

    sched_req_t    pending_reqs[$];
    tick_outcome_t tick_outcomes[$];
    sched_req_t    on_bus;
    int            queued_count   = 0;
    int            accepted_count = 0;
    int            error_count    = 0;
    int            cycle_count    = 0;
    int            hold_left      = 0;
    logic          hold_req       = 1'b0;
    logic          no_gaps        = 1'b0;

    rate_monotonic_tick_scheduler_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Model: a load rewrites one slot, a tick runs one unit and ages every active slot
    task automatic schedule_step(input sched_req_t r);
        int            active;
        bit            found;
        int            pick;
        logic [TIME_BITS-1:0] best;
        tick_outcome_t o;
        if (r.req == REQ_LOAD) begin
            if (int'(r.slot) < MAX_TASKS) begin
                ident_of[r.slot]   = r.ident;
                compute_of[r.slot] = r.compute;
                period_of[r.slot]  = r.period;
                work_left[r.slot]  = r.compute;
                countdown[r.slot]  = r.period;
            end
            return;
        end
        active = (int'(task_count_mirror) > MAX_TASKS) ? MAX_TASKS : int'(task_count_mirror);
        found  = 1'b0;
        pick   = 0;
        best   = '0;
        o      = '{idle: 1'b1, slot: '0, ident: '0, started: 1'b0, misses: '0};
        // smallest period wins, later slot on a tie
        for (int s = 0; s < active; s++) begin
            if (work_left[s] != 0 && (!found || period_of[s] <= best)) begin
                found = 1'b1;
                pick  = s;
                best  = period_of[s];
            end
        end
        if (found) begin
            o.idle    = 1'b0;
            o.slot    = SLOT_FW'(pick);
            o.ident   = ident_of[pick];
            o.started = (work_left[pick] == compute_of[pick]);
            work_left[pick] = work_left[pick] - 1'b1;
        end
        // release countdowns; expiry with work left is a miss
        for (int s = 0; s < active; s++) begin
            countdown[s] = countdown[s] - 1'b1;
            if (countdown[s] == 0) begin
                if (work_left[s] != 0 && s < MASK_W)
                    o.misses[s] = 1'b1;
                countdown[s] = period_of[s];
                work_left[s] = compute_of[s];
            end
        end
        tick_outcomes.push_back(o);
    endtask

    task automatic queue_req(input logic req, input int slot, input int ident,
                             input int compute, input int period);
        pending_reqs.push_back('{req: req, slot: SLOT_FW'(slot), ident: IDENT_W'(ident),
                                 compute: TIME_FW'(compute), period: TIME_FW'(period)});
        queued_count++;
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_req(REQ_TICK, $urandom_range(7), $urandom_range(255),
                             $urandom(), $urandom());
    endtask

    // Wait for every transaction to be taken and every outcome to arrive
    task automatic wait_quiet();
        do @(posedge aclk);
        while (accepted_count != queued_count || tick_outcomes.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_task_count(input int value);
        wait_quiet();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        task_count_mirror = COUNT_W'(value);
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Driver: predicts on each accepted transaction, then offers the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                schedule_step(on_bus);
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(99) >= 6)) begin
                    on_bus = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_bus.req;
                    s_tdata  <= S_TDATA_W'({on_bus.period, on_bus.compute,
                                            on_bus.ident, on_bus.slot});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_gaps || $urandom_range(99) >= 6;
        end
    end

    // Monitor: each result transaction against the oldest predicted outcome
    always @(posedge aclk) begin
        tick_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tick_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h/%0h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                want = tick_outcomes.pop_front();
                check_field("cpu_idle", want.idle, m_tuser);
                check_field("running_slot", want.slot, m_tdata[OUT_SLOT_LO +: SLOT_FW]);
                check_field("running_ident", want.ident, m_tdata[OUT_IDENT_LO +: IDENT_W]);
                check_field("job_started", want.started, m_tdata[OUT_START_BIT]);
                check_field("miss_mask", want.misses, m_tdata[OUT_MASK_LO +: MASK_W]);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rate_monotonic_tick_scheduler_top test failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int            phase;
        int            period;
        int            compute;
        task_count_mirror = 4'd1;
        for (int s = 0; s < MAX_TASKS; s++) begin
            ident_of[s]   = '0;
            compute_of[s] = '0;
            period_of[s]  = TIME_BITS'(1);
            work_left[s]  = '0;
            countdown[s]  = TIME_BITS'(1);
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset table with the default count: idle ticks only
        queue_ticks(2);

        // field extremes, zero period, tied periods, a task bound to miss
        write_task_count(8);
        queue_req(REQ_LOAD, 0, 8'hFF, 16'hFFFF, 16'hFFFF);
        queue_req(REQ_LOAD, 7, 8'h00, 16'h0000, 16'h0001);
        queue_req(REQ_LOAD, 1, 8'hA5, 3, 0);
        queue_req(REQ_LOAD, 2, 8'h11, 2, 2);
        queue_req(REQ_LOAD, 3, 8'h22, 2, 2);
        queue_req(REQ_LOAD, 4, 8'h5A, 5, 3);
        queue_ticks(10);

        // load into a slot outside the active range, then bring it in
        write_task_count(2);
        queue_req(REQ_LOAD, 6, 8'h66, 1, 1);
        queue_ticks(3);
        write_task_count(8);
        queue_ticks(2);

        // random task sets, each run for a stretch of ticks
        phase = 0;
        while (queued_count < ITEM_TARGET) begin
            case (phase)
                0:       write_task_count(15);
                1:       write_task_count(0);
                2:       write_task_count(8);
                3:       write_task_count(1);
                default: write_task_count(($urandom_range(9) < 7) ? $urandom_range(2, 8)
                                                                  : $urandom_range(15));
            endcase
            no_gaps = (phase >= 5 && phase <= 7);
            for (int s = 0; s < MAX_TASKS; s++) begin
                if ($urandom_range(9) < 8) begin
                    case ($urandom_range(19))
                        0: begin
                            period  = $urandom_range(16'hFFFF);
                            compute = $urandom_range(16'hFFFF);
                        end
                        1: begin
                            period  = 0;
                            compute = $urandom_range(6);
                        end
                        default: begin
                            period  = $urandom_range(1, 24);
                            compute = $urandom_range(0, period / 2 + 3);
                        end
                    endcase
                    queue_req(REQ_LOAD, s, $urandom_range(255), compute, period);
                end
            end
            // ticks with the odd reload of a random slot mixed in
            repeat ($urandom_range(25, 60)) begin
                if ($urandom_range(99) < 8)
                    queue_req(REQ_LOAD, $urandom_range(7), $urandom_range(255),
                              $urandom_range(0, 8), $urandom_range(1, 12));
                else
                    queue_ticks(1);
            end
            if (phase == 3)
                hold_req = 1'b1;
            phase++;
        end

        wait_quiet();
        if (error_count == 0)
            $display("rate_monotonic_tick_scheduler_top test passed");
        else
            $display("rate_monotonic_tick_scheduler_top test failed");
        $finish;
    end

endmodule
